// ===== hw/rtl/bbs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bbs_pkg;

    localparam int MAX_ROWS      = 256;
    localparam int COUNT_BITS    = 16;
    localparam int FRACTION_BITS = 24;

    // row index into the count memory, and a row count that can hold MAX_ROWS itself
    localparam int ROW_BITS  = $clog2(MAX_ROWS);
    localparam int NROW_BITS = ROW_BITS + 1;
    // sum of all row counts
    localparam int TOTAL_BITS = COUNT_BITS + ROW_BITS;
    localparam int SCALE_BITS = FRACTION_BITS + TOTAL_BITS;

    localparam int CFG_DATA_BITS  = 16;
    localparam int CFG_INDEX_BITS = 2;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_ROWS_IN_USE    = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_RESAMPLE_COUNT = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_UNBIASED_MODE  = 2'd2;

    typedef logic [ROW_BITS-1:0]   t_row;
    typedef logic [NROW_BITS-1:0]  t_nrow;
    typedef logic [COUNT_BITS-1:0] t_count;
    typedef logic [TOTAL_BITS-1:0] t_total;

endpackage

`default_nettype wire

// ===== hw/rtl/balanced_bootstrap_sampler_top.sv =====
// Balanced bootstrap sampler. Each input item carries a 0.24 random fraction and yields one
// result item: the chosen row (from one), its position within the resample, the resample
// number and a flag on the final draw of the final resample. Row counts live in a 256 x 16
// memory with a registered read; a valid bit per row makes reset, a configuration
// write and the reload after the final draw take effect at once, with no clearing pass. One
// item is in work at a time: the row is chosen by a walk over the cumulative counts, which
// reads one memory entry per cycle. The next item is taken while a finished result waits
// in the output register. Configuration writes are to be made only while the block is idle;
// the block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none

module balanced_bootstrap_sampler_top (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,

    input  wire logic                                 i_cfg_we,
    input  wire logic [bbs_pkg::CFG_INDEX_BITS-1:0]   i_cfg_index,
    input  wire logic [bbs_pkg::CFG_DATA_BITS-1:0]    i_cfg_data,

    input  wire logic                                 i_valid,
    output logic                                      o_stall,
    input  wire logic [bbs_pkg::FRACTION_BITS-1:0]    i_random_fraction,

    output logic                                      o_valid,
    input  wire logic                                 i_stall,
    output logic [bbs_pkg::NROW_BITS-1:0]             o_sample_index,
    output logic [bbs_pkg::ROW_BITS-1:0]              o_row_position,
    output logic [bbs_pkg::COUNT_BITS-1:0]            o_resample_number,
    output logic                                      o_last_draw
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RDX  = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_SCAN = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0] r_state;

    bbs_pkg::t_nrow   r_rows;
    bbs_pkg::t_count  r_rcount;
    logic             r_unb;
    logic             r_reload_pend;

    logic [bbs_pkg::MAX_ROWS-1:0] r_vld;
    bbs_pkg::t_total  r_total;
    bbs_pkg::t_row    r_pos;
    bbs_pkg::t_count  r_rc;
    bbs_pkg::t_row    r_excl;

    logic             r_leave;
    bbs_pkg::t_row    r_j;
    bbs_pkg::t_total  r_cum;
    bbs_pkg::t_row    r_chosen;
    logic             r_out_valid;

    logic [bbs_pkg::FRACTION_BITS-1:0] r_frac;
    bbs_pkg::t_total  r_avail;
    bbs_pkg::t_total  r_k;

    bbs_pkg::t_nrow   w_eff_n;
    bbs_pkg::t_count  w_eff_c;
    logic [bbs_pkg::NROW_BITS+bbs_pkg::COUNT_BITS-1:0] w_prod_nc;
    bbs_pkg::t_total  w_reload_total;
    logic [bbs_pkg::SCALE_BITS-1:0] w_scaled;

    bbs_pkg::t_row    w_cur_row;
    bbs_pkg::t_count  w_ram_q;
    bbs_pkg::t_count  w_cnt;
    bbs_pkg::t_count  w_cnt_eff;
    bbs_pkg::t_total  w_cum;
    logic             w_hit;
    logic             w_last_row;
    logic             w_leave;
    logic             w_pos_wrap;
    logic             w_last;
    logic             w_out_free;
    logic             w_cfg_hit;

    bbs_pkg::t_row    w_raddr;
    logic             w_we;

    always_comb begin
        w_eff_n = r_rows;
        if (r_rows == '0) begin
            w_eff_n = bbs_pkg::NROW_BITS'(1);
        end else if (r_rows > bbs_pkg::NROW_BITS'(bbs_pkg::MAX_ROWS)) begin
            w_eff_n = bbs_pkg::NROW_BITS'(bbs_pkg::MAX_ROWS);
        end
        w_eff_c = (r_rcount == '0) ? bbs_pkg::COUNT_BITS'(1) : r_rcount;

        w_prod_nc      = (bbs_pkg::NROW_BITS + bbs_pkg::COUNT_BITS)'(w_eff_n) *
                         (bbs_pkg::NROW_BITS + bbs_pkg::COUNT_BITS)'(w_eff_c);
        w_reload_total = w_prod_nc[bbs_pkg::TOTAL_BITS-1:0];

        w_scaled = bbs_pkg::SCALE_BITS'(r_frac) * bbs_pkg::SCALE_BITS'(r_avail);

        // rows never written since the last reload read as their reload value
        w_cur_row = (r_state == S_RDX) ? r_excl : r_j;
        if (r_vld[w_cur_row]) begin
            w_cnt = w_ram_q;
        end else if ({1'b0, w_cur_row} < w_eff_n) begin
            w_cnt = w_eff_c;
        end else begin
            w_cnt = '0;
        end
        w_cnt_eff = (r_leave && (r_j == r_excl)) ? '0 : w_cnt;

        w_cum      = r_cum + bbs_pkg::TOTAL_BITS'(w_cnt_eff);
        w_hit      = r_k < w_cum;
        w_last_row = ({1'b0, r_j} == (w_eff_n - bbs_pkg::NROW_BITS'(1)));
        w_leave    = r_unb && (bbs_pkg::TOTAL_BITS'(w_cnt) != r_total);

        w_pos_wrap = ({1'b0, r_pos} + bbs_pkg::NROW_BITS'(1)) >= w_eff_n;
        w_last     = w_pos_wrap &&
                     (({1'b0, r_rc} + (bbs_pkg::COUNT_BITS + 1)'(1)) >= {1'b0, w_eff_c});
        w_out_free = !r_out_valid || !i_stall;

        w_cfg_hit = i_cfg_we && ((i_cfg_index == bbs_pkg::CFG_ROWS_IN_USE) ||
                                 (i_cfg_index == bbs_pkg::CFG_RESAMPLE_COUNT) ||
                                 (i_cfg_index == bbs_pkg::CFG_UNBIASED_MODE));

        unique case (r_state)
            S_MUL:   w_raddr = '0;
            S_SCAN:  w_raddr = r_j + bbs_pkg::ROW_BITS'(1);
            default: w_raddr = r_excl;
        endcase
        w_we = (r_state == S_SCAN) && w_hit;
    end

    bbs_ram #(
        .WIDTH (bbs_pkg::COUNT_BITS),
        .DEPTH (bbs_pkg::MAX_ROWS)
    ) u_counts (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_j),
        .i_wdata (w_cnt - bbs_pkg::COUNT_BITS'(1)),
        .i_raddr (w_raddr),
        .o_rdata (w_ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_rows        <= bbs_pkg::NROW_BITS'(1);
            r_rcount      <= bbs_pkg::COUNT_BITS'(1);
            r_unb         <= 1'b0;
            r_reload_pend <= 1'b0;
            r_vld         <= '0;
            r_total       <= bbs_pkg::TOTAL_BITS'(1);
            r_pos         <= '0;
            r_rc          <= '0;
            r_excl        <= '0;
            r_leave       <= 1'b0;
            r_j           <= '0;
            r_cum         <= '0;
            r_chosen      <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (r_out_valid && !i_stall && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end

            // total follows the new configuration in the cycle after the write, through r_reload_pend
            if (r_reload_pend) begin
                r_total <= w_reload_total;
            end
            r_reload_pend <= w_cfg_hit;

            if (w_cfg_hit) begin
                unique case (i_cfg_index)
                    bbs_pkg::CFG_ROWS_IN_USE:    r_rows   <= i_cfg_data[bbs_pkg::NROW_BITS-1:0];
                    bbs_pkg::CFG_RESAMPLE_COUNT: r_rcount <= i_cfg_data[bbs_pkg::COUNT_BITS-1:0];
                    default:                     r_unb    <= i_cfg_data[0];
                endcase
                r_vld         <= '0;
                r_pos         <= '0;
                r_rc          <= '0;
                r_excl        <= '0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_state <= S_RDX;
                    end
                end
                S_RDX: begin
                    r_leave <= w_leave;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_j   <= '0;
                    r_cum <= '0;
                    if (r_avail == '0) begin
                        r_chosen <= '0;
                        r_state  <= S_DONE;
                    end else begin
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_cum <= w_cum;
                    if (w_hit) begin
                        r_chosen   <= r_j;
                        r_vld[r_j] <= 1'b1;
                        r_total    <= r_total - bbs_pkg::TOTAL_BITS'(1);
                        r_state    <= S_DONE;
                    end else if (w_last_row) begin
                        r_chosen <= '0;
                        r_state  <= S_DONE;
                    end else begin
                        r_j <= r_j + bbs_pkg::ROW_BITS'(1);
                    end
                end
                S_DONE: begin
                    // hold the result until the output register frees up
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                        if (w_last) begin
                            r_vld   <= '0;
                            r_total <= w_reload_total;
                            r_pos   <= '0;
                            r_rc    <= '0;
                            r_excl  <= '0;
                        end else if (w_pos_wrap) begin
                            r_pos <= '0;
                            r_rc  <= r_rc + bbs_pkg::COUNT_BITS'(1);
                            // excluded row tracks the resample number modulo the rows
                            if ({1'b0, r_excl} + bbs_pkg::NROW_BITS'(1) >= w_eff_n) begin
                                r_excl <= '0;
                            end else begin
                                r_excl <= r_excl + bbs_pkg::ROW_BITS'(1);
                            end
                        end else begin
                            r_pos <= r_pos + bbs_pkg::ROW_BITS'(1);
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && i_valid) begin
            r_frac <= i_random_fraction;
        end
        if (r_state == S_RDX) begin
            r_avail <= w_leave ? (r_total - bbs_pkg::TOTAL_BITS'(w_cnt)) : r_total;
        end
        if (r_state == S_MUL) begin
            r_k <= w_scaled[bbs_pkg::FRACTION_BITS +: bbs_pkg::TOTAL_BITS];
        end
        if ((r_state == S_DONE) && w_out_free) begin
            o_sample_index    <= {1'b0, r_chosen} + bbs_pkg::NROW_BITS'(1);
            o_row_position    <= r_pos;
            o_resample_number <= r_rc;
            o_last_draw       <= w_last;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;

endmodule

`default_nettype wire

// ===== hw/rtl/bbs_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bbs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    localparam int RANDOM_ITEMS = 1250;
    localparam int QUIET_ITEMS  = 150;
    localparam int HANG_LIMIT   = 5000;
    localparam int END_WAIT     = 300;
    localparam logic [bbs_pkg::CFG_INDEX_BITS-1:0] CFG_SPARE_INDEX = 2'd3;

    typedef struct packed {
        bbs_pkg::t_nrow  index;
        bbs_pkg::t_row   position;
        bbs_pkg::t_count resample;
        logic            last;
    } t_draw;

    logic                               i_clk = 1'b0;
    logic                               i_rst_n = 1'b0;
    logic                               i_cfg_we = 1'b0;
    logic [bbs_pkg::CFG_INDEX_BITS-1:0] i_cfg_index = '0;
    logic [bbs_pkg::CFG_DATA_BITS-1:0]  i_cfg_data = '0;
    logic                               i_valid = 1'b0;
    logic                               o_stall;
    logic [bbs_pkg::FRACTION_BITS-1:0]  i_random_fraction = '0;
    logic                               o_valid;
    logic                               i_stall = 1'b0;
    bbs_pkg::t_nrow                     o_sample_index;
    bbs_pkg::t_row                      o_row_position;
    bbs_pkg::t_count                    o_resample_number;
    logic                               o_last_draw;

    balanced_bootstrap_sampler_top dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_random_fraction (i_random_fraction),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_sample_index    (o_sample_index),
        .o_row_position    (o_row_position),
        .o_resample_number (o_resample_number),
        .o_last_draw       (o_last_draw)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // sampler model: register copies and token state
    bbs_pkg::t_nrow  rows_reg;
    bbs_pkg::t_count resamples_reg;
    logic            bootknife_reg;
    bbs_pkg::t_count row_tokens [bbs_pkg::MAX_ROWS];
    bbs_pkg::t_total tokens_left;
    int unsigned     draw_pos;
    int unsigned     resample_idx;
    int unsigned     skip_row;

    logic [bbs_pkg::FRACTION_BITS-1:0] pending_fractions [$];
    t_draw                             expected_draws [$];

    int  errors = 0;
    bit  idle_on = 1'b0;
    bit  quiet = 1'b0;
    int  send_gap = 0;
    int  stall_left = 0;
    int  hang_count = 0;

    function automatic int unsigned active_rows();
        if (rows_reg == '0) return 1;
        if (rows_reg > bbs_pkg::MAX_ROWS) return bbs_pkg::MAX_ROWS;
        return 32'(rows_reg);
    endfunction

    function automatic int unsigned active_resamples();
        return (resamples_reg == '0) ? 32'd1 : 32'(resamples_reg);
    endfunction

    task automatic refill_tokens();
        int unsigned n;
        n = active_rows();
        for (int j = 0; j < bbs_pkg::MAX_ROWS; j++)
            row_tokens[j] = (j < int'(n)) ? bbs_pkg::t_count'(active_resamples()) : '0;
        tokens_left  = bbs_pkg::t_total'(n * active_resamples());
        draw_pos     = 0;
        resample_idx = 0;
        skip_row     = 0;
    endtask

    task automatic apply_register_write(input logic [bbs_pkg::CFG_INDEX_BITS-1:0] idx,
                                        input logic [bbs_pkg::CFG_DATA_BITS-1:0] data);
        case (idx)
            bbs_pkg::CFG_ROWS_IN_USE: begin
                rows_reg = data[bbs_pkg::NROW_BITS-1:0];
            end
            bbs_pkg::CFG_RESAMPLE_COUNT: begin
                resamples_reg = data[bbs_pkg::COUNT_BITS-1:0];
            end
            bbs_pkg::CFG_UNBIASED_MODE: begin
                bootknife_reg = data[0];
            end
            default: begin
                return;
            end
        endcase
        refill_tokens();
    endtask

    task automatic predict_draw(input logic [bbs_pkg::FRACTION_BITS-1:0] frac);
        int unsigned       n;
        int unsigned       r;
        int unsigned       chosen;
        bit                leave;
        bit                found;
        bit                last;
        longint unsigned   avail;
        longint unsigned   k;
        longint unsigned   cum;
        longint unsigned   f;
        t_draw             d;
        n      = active_rows();
        r      = skip_row % n;
        leave  = 1'b0;
        found  = 1'b0;
        avail  = 64'(tokens_left);
        cum    = 0;
        chosen = 0;
        f      = 64'(frac);
        // leave the skipped row out unless it holds every token left
        if (bootknife_reg && bbs_pkg::t_total'(row_tokens[r]) != tokens_left) begin
            leave = 1'b1;
            avail = 64'(tokens_left - bbs_pkg::t_total'(row_tokens[r]));
        end
        k = (f * avail) >> bbs_pkg::FRACTION_BITS;
        if (avail > 0) begin
            for (int unsigned j = 0; j < n && !found; j++) begin
                if (!(leave && j == r))
                    cum += 64'(row_tokens[j]);
                if (k < cum) begin
                    found  = 1'b1;
                    chosen = j;
                    row_tokens[j] = row_tokens[j] - bbs_pkg::t_count'(1);
                    tokens_left   = tokens_left - bbs_pkg::t_total'(1);
                end
            end
        end
        last       = (draw_pos + 1 >= n) && (resample_idx + 1 >= active_resamples());
        d.index    = bbs_pkg::t_nrow'(chosen + 1);
        d.position = bbs_pkg::t_row'(draw_pos);
        d.resample = bbs_pkg::t_count'(resample_idx);
        d.last     = last;
        expected_draws.push_back(d);
        if (last) begin
            refill_tokens();
        end else begin
            draw_pos++;
            if (draw_pos >= n) begin
                draw_pos = 0;
                resample_idx++;
                skip_row = resample_idx % n;
            end
        end
    endtask

    // driver: model the register writes and accepted items, then present the next item
    always @(posedge i_clk) begin
        if (i_cfg_we)
            apply_register_write(i_cfg_index, i_cfg_data);
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall)
                predict_draw(i_random_fraction);
            if (!i_valid || !o_stall) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_valid <= 1'b0;
                end else if (pending_fractions.size() != 0) begin
                    i_valid <= 1'b1;
                    i_random_fraction <= pending_fractions.pop_front();
                    if (idle_on && !quiet && $urandom_range(0, 4) == 0)
                        send_gap = $urandom_range(1, 7);
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: check each accepted result item, then pick the next stall
    always @(posedge i_clk) begin
        t_draw want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_draws.size() == 0) begin
                $error("unexpected result item: sample_index %0d", o_sample_index);
                errors++;
            end else begin
                want = expected_draws.pop_front();
                if (o_sample_index !== want.index) begin
                    $error("sample_index: expected %0d, actual %0d", want.index, o_sample_index);
                    errors++;
                end
                if (o_row_position !== want.position) begin
                    $error("row_position: expected %0d, actual %0d",
                           want.position, o_row_position);
                    errors++;
                end
                if (o_resample_number !== want.resample) begin
                    $error("resample_number: expected %0d, actual %0d",
                           want.resample, o_resample_number);
                    errors++;
                end
                if (o_last_draw !== want.last) begin
                    $error("last_draw: expected %0d, actual %0d", want.last, o_last_draw);
                    errors++;
                end
            end
        end
        if (stall_left > 0) begin
            stall_left--;
            i_stall <= 1'b1;
        end else if (idle_on && !quiet && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(0, 6);
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // watchdog: count cycles with no item moving on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall))
            hang_count <= 0;
        else
            hang_count <= hang_count + 1;
        if (hang_count >= HANG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic write_reg(input logic [bbs_pkg::CFG_INDEX_BITS-1:0] idx,
                             input logic [bbs_pkg::CFG_DATA_BITS-1:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
    endtask

    task automatic end_writes();
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // write all three registers in a randomly rotated order; optionally set unused upper data bits
    task automatic set_mode(input int rows, input int count, input bit unb, input bit messy);
        int rot;
        logic [bbs_pkg::CFG_DATA_BITS-1:0] junk;
        rot  = $urandom_range(0, 2);
        junk = messy ? bbs_pkg::CFG_DATA_BITS'($urandom_range(1, 127)) : '0;
        for (int w = 0; w < 3; w++) begin
            case ((w + rot) % 3)
                0: write_reg(bbs_pkg::CFG_ROWS_IN_USE,
                             (junk << bbs_pkg::NROW_BITS) | bbs_pkg::CFG_DATA_BITS'(rows));
                1: write_reg(bbs_pkg::CFG_RESAMPLE_COUNT, bbs_pkg::CFG_DATA_BITS'(count));
                default: write_reg(bbs_pkg::CFG_UNBIASED_MODE,
                                   (junk << 1) | bbs_pkg::CFG_DATA_BITS'(unb));
            endcase
        end
        end_writes();
    endtask

    task automatic wait_drained();
        do
            @(negedge i_clk);
        while (pending_fractions.size() != 0 || expected_draws.size() != 0 || i_valid || o_valid);
    endtask

    task automatic queue_random_fractions(input int count);
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(0, 9))
                0: pending_fractions.push_back('0);
                1: pending_fractions.push_back('1);
                default: pending_fractions.push_back(bbs_pkg::FRACTION_BITS'($urandom()));
            endcase
        end
    endtask

    initial begin : stimulus
        int sent;
        int phase;
        int rows;
        int count;
        int n_items;
        int half;
        bit unb;
        rows_reg      = bbs_pkg::t_nrow'(1);
        resamples_reg = bbs_pkg::t_count'(1);
        bootknife_reg = 1'b0;
        refill_tokens();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset settings: one row, one resample, every draw is the last
        pending_fractions.push_back('0);
        pending_fractions.push_back('1);
        wait_drained();

        // one full plain pass over four rows
        set_mode(4, 2, 1'b0, 1'b0);
        pending_fractions.push_back(24'h000000);
        pending_fractions.push_back(24'hFFFFFF);
        pending_fractions.push_back(24'h800000);
        pending_fractions.push_back(24'h000001);
        pending_fractions.push_back(24'hFFFFFE);
        pending_fractions.push_back(24'h400000);
        pending_fractions.push_back(24'hC00000);
        pending_fractions.push_back(24'h7FFFFF);
        wait_drained();

        // bootknife over three rows, through the reload into the next pass
        set_mode(3, 2, 1'b1, 1'b0);
        pending_fractions.push_back(24'hFFFFFF);
        pending_fractions.push_back(24'h000000);
        pending_fractions.push_back(24'hFFFFFF);
        pending_fractions.push_back(24'h555555);
        pending_fractions.push_back(24'hAAAAAA);
        pending_fractions.push_back(24'hFFFFFF);
        pending_fractions.push_back(24'h000000);
        wait_drained();

        // zero rows and zero resamples act as one; the spare index changes nothing
        set_mode(0, 0, 1'b1, 1'b0);
        write_reg(CFG_SPARE_INDEX, 16'hFFFF);
        end_writes();
        pending_fractions.push_back(24'hFFFFFF);
        pending_fractions.push_back(24'h123456);
        wait_drained();

        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            quiet   = (sent >= RANDOM_ITEMS - QUIET_ITEMS);
            idle_on = ($urandom_range(0, 3) != 0);
            case (phase)
                0: begin
                    rows = bbs_pkg::MAX_ROWS; count = 65535; unb = 1'b0; n_items = 120;
                end
                1: begin
                    rows = bbs_pkg::MAX_ROWS; count = 1; unb = 1'b1; n_items = 300;
                end
                2: begin
                    rows = 9'h1FF; count = 0; unb = 1'b0; n_items = 40;
                end
                3: begin
                    rows = 2; count = 65535; unb = 1'b1; n_items = 80;
                end
                default: begin
                    if ($urandom_range(0, 7) == 0) begin
                        rows    = $urandom_range(10, bbs_pkg::MAX_ROWS);
                        n_items = 40;
                    end else begin
                        rows    = $urandom_range(1, 9);
                        n_items = $urandom_range(40, 100);
                    end
                    count = $urandom_range(1, 8);
                    unb   = $urandom_range(0, 1);
                end
            endcase
            set_mode(rows, count, unb, phase >= 4 && $urandom_range(0, 2) == 0);
            half = n_items / 2;
            queue_random_fractions(half);
            // on a coin flip, hold the sender until every result is back
            if ($urandom_range(0, 1) == 1)
                wait_drained();
            queue_random_fractions(n_items - half);
            wait_drained();
            sent += n_items;
            phase++;
        end

        repeat (END_WAIT) @(posedge i_clk);
        if (errors == 0 && expected_draws.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            if (expected_draws.size() != 0)
                $error("%0d expected result items never arrived", expected_draws.size());
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== balanced_bootstrap_sampler_top.f =====
hw/rtl/bbs_pkg.sv
hw/rtl/bbs_ram.sv
hw/rtl/balanced_bootstrap_sampler_top.sv
tb/tb_top.sv
